/* hdl/atdsf_pkg.sv */
// Package for the aligned top-down slot finder.
// Holds sizes, codes and shared types; no dependencies.
package atdsf_pkg;

	localparam int unsigned DATA_W     = 64;
	localparam int unsigned MAX_RANGES = 16;
	localparam int unsigned ALIGN_BITS = 21;
	localparam int unsigned IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int unsigned STATUS_W   = 3;
	localparam int unsigned CFG_IDX_W  = 1;

	localparam logic [DATA_W-1:0] ALIGN_MASK = (64'd1 << ALIGN_BITS) - 64'd1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_BASE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_SIZE = 1'd1;

	localparam logic [DATA_W-1:0] MEMORY_BASE_RST = 64'h0000_0000_8000_0000;
	localparam logic [DATA_W-1:0] MEMORY_SIZE_RST = 64'h0000_0000_0800_0000;

	typedef enum logic {
		OP_RECORD = 1'b0,
		OP_QUERY  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK       = 3'd0,
		STAT_SIZE     = 3'd1,
		STAT_NOSLOT   = 3'd2,
		STAT_OVERFLOW = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] res;
		logic              flag;   // carry on add, borrow (a < b) on subtract
	} alu_rsp_t;

	typedef enum logic [3:0] {
		FSM_IDLE,
		FSM_OVF,
		FSM_SIZE,
		FSM_TOP,
		FSM_AVAIL,
		FSM_FIT,
		FSM_CAND,
		FSM_BASE,
		FSM_PEND,
		FSM_SEND,
		FSM_SBEG,
		FSM_SLOW,
		FSM_DECIDE,
		FSM_FINISH
	} fsm_t;

endpackage

/* hdl/atdsf_req_if.sv */
// Request channel of the slot finder: record or query items.
// Depends on atdsf_pkg for field widths.
interface atdsf_req_if import atdsf_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              operation;
	logic [DATA_W-1:0] range_begin;
	logic [DATA_W-1:0] range_length;
	logic [DATA_W-1:0] request_size;

	modport source (output valid, output operation, output range_begin,
		output range_length, output request_size, input ready);
	modport sink (input valid, input operation, input range_begin,
		input range_length, input request_size, output ready);
endinterface

/* hdl/atdsf_rsp_if.sv */
// Result channel of the slot finder: slot address and status.
// Depends on atdsf_pkg for field widths.
interface atdsf_rsp_if import atdsf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   slot_address;
	logic [STATUS_W-1:0] status;

	modport source (output valid, output slot_address, output status, input ready);
	modport sink (input valid, input slot_address, input status, output ready);
endinterface

/* hdl/atdsf_cfg_if.sv */
// Configuration write channel of the slot finder.
// Depends on atdsf_pkg for index and data widths.
interface atdsf_cfg_if import atdsf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [DATA_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/atdsf_alu.sv */
// Shared 64-bit add/subtract unit of the slot finder.
// Depends on atdsf_pkg for the request and response structs.
module atdsf_alu import atdsf_pkg::*; (
	input  alu_req_t alu_req,
	output alu_rsp_t alu_rsp
);

	logic [DATA_W:0] wide;

	// Add or subtract with the carry or borrow in the top bit
	always_comb begin
		case (alu_req.op)
			ALU_ADD: wide = {1'b0, alu_req.a} + {1'b0, alu_req.b};
			ALU_SUB: wide = {1'b0, alu_req.a} - {1'b0, alu_req.b};
			default: wide = '0;
		endcase
		alu_rsp.res  = wide[DATA_W-1:0];
		alu_rsp.flag = wide[DATA_W];
	end

endmodule

/* hdl/aligned_top_down_slot_finder_top.sv */
// Top level of the aligned top-down slot finder: sequencer, range table, result register.
// Depends on atdsf_pkg, the three channel interfaces and atdsf_alu.
//
// A record request goes from the idle state through the finish state into the output
// register. A query runs the overflow, size and top steps, then per ceiling step (at
// most 17) the avail, fit, candidate, base, pend, range walk (up to 16 entries: send,
// then begin and low where needed) and decide steps; the finish state hands off the
// result. Every arithmetic step uses the single shared 64-bit adder/subtractor, one
// operation a cycle. The request side is ready only while the sequencer is idle; a
// finished result waits in the output register, so a new request can be taken while
// the previous result is unclaimed.
// Configuration writes are always accepted and must only be made while idle.
module aligned_top_down_slot_finder_top import atdsf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	atdsf_req_if.sink   req,
	atdsf_rsp_if.source rsp,
	atdsf_cfg_if.sink   cfg
);

	fsm_t state_q, state_d;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;

	logic [DATA_W-1:0] mem_base_q, mem_size_q;
	logic [DATA_W-1:0] req_size_q, req_size_d;
	logic [DATA_W-1:0] ceiling_q, ceiling_d;
	logic [DATA_W-1:0] avail_q, avail_d;
	logic [DATA_W-1:0] cand_q, cand_d;
	logic [DATA_W-1:0] pend_q, pend_d;
	logic [DATA_W-1:0] low_q, low_d;
	logic              hit_q, hit_d;
	logic [IDX_W-1:0]  idx_q, idx_d;
	logic [CNT_W-1:0]  iter_q, iter_d;
	logic [CNT_W-1:0]  count_q;
	logic              table_we;
	logic              last_entry;

	logic [DATA_W-1:0] starts_q [MAX_RANGES];
	logic [DATA_W-1:0] ends_q   [MAX_RANGES];

	logic [DATA_W-1:0] res_addr_q, res_addr_d;
	status_t           res_status_q, res_status_d;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_addr_q;
	status_t           out_status_q;
	logic              out_load;

	atdsf_alu u_alu (
		.alu_req (alu_req),
		.alu_rsp (alu_rsp)
	);

	assign last_entry = (CNT_W'(idx_q) + CNT_W'(1)) == count_q;
	assign out_load   = (state_q == FSM_FINISH) && (!out_valid_q || rsp.ready);

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the shared unit through the query steps
	always_comb begin
		state_d      = state_q;
		req.ready    = 1'b0;
		table_we     = 1'b0;
		alu_req      = '{op: ALU_SUB, a: '0, b: '0};
		req_size_d   = req_size_q;
		ceiling_d    = ceiling_q;
		avail_d      = avail_q;
		cand_d       = cand_q;
		pend_d       = pend_q;
		low_d        = low_q;
		hit_d        = hit_q;
		idx_d        = idx_q;
		iter_d       = iter_q;
		res_addr_d   = res_addr_q;
		res_status_d = res_status_q;
		case (state_q)
			FSM_IDLE: begin
				req.ready = 1'b1;
				alu_req   = '{op: ALU_ADD, a: req.range_begin, b: req.range_length};
				if (req.valid) begin
					res_addr_d = '0;
					if (req.operation == OP_RECORD) begin
						res_status_d = STAT_OK;
						if (req.range_length == '0) begin
							res_status_d = STAT_OK;
						end else if (count_q >= CNT_W'(MAX_RANGES)) begin
							res_status_d = STAT_FULL;
						end else begin
							table_we = 1'b1;
						end
						state_d = FSM_FINISH;
					end else begin
						req_size_d = req.request_size;
						state_d    = FSM_OVF;
					end
				end
			end
			FSM_OVF: begin
				// Borrow means memory_size > ~memory_base: region passes the top
				alu_req = '{op: ALU_SUB, a: ~mem_base_q, b: mem_size_q};
				if (alu_rsp.flag) begin
					res_status_d = STAT_OVERFLOW;
					state_d      = FSM_FINISH;
				end else begin
					state_d = FSM_SIZE;
				end
			end
			FSM_SIZE: begin
				alu_req = '{op: ALU_SUB, a: mem_size_q, b: req_size_q};
				if (alu_rsp.flag || req_size_q == '0) begin
					res_status_d = STAT_SIZE;
					state_d      = FSM_FINISH;
				end else begin
					state_d = FSM_TOP;
				end
			end
			FSM_TOP: begin
				alu_req   = '{op: ALU_ADD, a: mem_base_q, b: mem_size_q};
				ceiling_d = alu_rsp.res;
				iter_d    = '0;
				state_d   = FSM_AVAIL;
			end
			FSM_AVAIL: begin
				alu_req = '{op: ALU_SUB, a: ceiling_q, b: mem_base_q};
				avail_d = alu_rsp.res;
				if (alu_rsp.flag) begin
					res_status_d = STAT_NOSLOT;
					state_d      = FSM_FINISH;
				end else begin
					state_d = FSM_FIT;
				end
			end
			FSM_FIT: begin
				alu_req = '{op: ALU_SUB, a: avail_q, b: req_size_q};
				if (alu_rsp.flag) begin
					res_status_d = STAT_NOSLOT;
					state_d      = FSM_FINISH;
				end else begin
					state_d = FSM_CAND;
				end
			end
			FSM_CAND: begin
				alu_req = '{op: ALU_SUB, a: ceiling_q, b: req_size_q};
				cand_d  = alu_rsp.res & ~ALIGN_MASK;
				state_d = FSM_BASE;
			end
			FSM_BASE: begin
				alu_req = '{op: ALU_SUB, a: cand_q, b: mem_base_q};
				if (alu_rsp.flag) begin
					res_status_d = STAT_NOSLOT;
					state_d      = FSM_FINISH;
				end else begin
					state_d = FSM_PEND;
				end
			end
			FSM_PEND: begin
				alu_req = '{op: ALU_ADD, a: cand_q, b: req_size_q};
				pend_d  = alu_rsp.res;
				idx_d   = '0;
				hit_d   = 1'b0;
				state_d = (count_q == '0) ? FSM_DECIDE : FSM_SEND;
			end
			FSM_SEND: begin
				// Candidate starts below this range's end
				alu_req = '{op: ALU_SUB, a: cand_q, b: ends_q[idx_q]};
				if (alu_rsp.flag) begin
					state_d = FSM_SBEG;
				end else if (last_entry) begin
					state_d = FSM_DECIDE;
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			FSM_SBEG: begin
				// Range begins below the candidate's end: a collision
				alu_req = '{op: ALU_SUB, a: starts_q[idx_q], b: pend_q};
				if (alu_rsp.flag && hit_q) begin
					state_d = FSM_SLOW;
				end else begin
					if (alu_rsp.flag) begin
						hit_d = 1'b1;
						low_d = starts_q[idx_q];
					end
					if (last_entry) begin
						state_d = FSM_DECIDE;
					end else begin
						idx_d   = idx_q + IDX_W'(1);
						state_d = FSM_SEND;
					end
				end
			end
			FSM_SLOW: begin
				// Keep the lowest colliding begin
				alu_req = '{op: ALU_SUB, a: starts_q[idx_q], b: low_q};
				if (alu_rsp.flag) begin
					low_d = starts_q[idx_q];
				end
				if (last_entry) begin
					state_d = FSM_DECIDE;
				end else begin
					idx_d   = idx_q + IDX_W'(1);
					state_d = FSM_SEND;
				end
			end
			FSM_DECIDE: begin
				if (!hit_q) begin
					res_addr_d   = cand_q;
					res_status_d = STAT_OK;
					state_d      = FSM_FINISH;
				end else if (iter_q == CNT_W'(MAX_RANGES)) begin
					res_status_d = STAT_NOSLOT;
					state_d      = FSM_FINISH;
				end else begin
					ceiling_d = low_q;
					iter_d    = iter_q + CNT_W'(1);
					state_d   = FSM_AVAIL;
				end
			end
			FSM_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// Advance the query working registers
	always_ff @(posedge clk) begin
		req_size_q   <= req_size_d;
		ceiling_q    <= ceiling_d;
		avail_q      <= avail_d;
		cand_q       <= cand_d;
		pend_q       <= pend_d;
		low_q        <= low_d;
		res_addr_q   <= res_addr_d;
		res_status_q <= res_status_d;
	end

	// Hold loop counters and the hit flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			idx_q  <= '0;
			iter_q <= '0;
		end else begin
			hit_q  <= hit_d;
			idx_q  <= idx_d;
			iter_q <= iter_d;
		end
	end

	// Store a recorded range; the end wraps modulo 2^64
	always_ff @(posedge clk) begin
		if (table_we) begin
			starts_q[count_q[IDX_W-1:0]] <= req.range_begin;
			ends_q[count_q[IDX_W-1:0]]   <= alu_rsp.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (table_we) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Take configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_base_q <= MEMORY_BASE_RST;
			mem_size_q <= MEMORY_SIZE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_MEMORY_BASE: mem_base_q <= cfg.data;
				CFG_MEMORY_SIZE: mem_size_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Hold the result until the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.slot_address = out_addr_q;
	assign rsp.status       = out_status_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RANGES))
		else $error("range count past table depth");

	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		iter_q <= CNT_W'(MAX_RANGES))
		else $error("ceiling step count past limit");

	a_record_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.operation == OP_RECORD
			&& req.range_length != '0 && count_q < CNT_W'(MAX_RANGES))
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted record did not enter the table");

	a_ok_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == STAT_OK) |-> (rsp.slot_address & ALIGN_MASK) == '0)
		else $error("slot address not aligned");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_OK) |-> rsp.slot_address == '0)
		else $error("error result carries an address");
`endif

endmodule
